/* sv/assert_macros.svh */
// assertion macros used by rtap_checker
// each macro expects a clock named clk in scope; ASSERT_NOW and ASSERT_NEXT also a reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, checked during reset as well
`define ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/rtap_pkg.sv */
// types and constants for the rom trap automap pager
// no dependencies
`timescale 1ns / 1ps

package rtap_pkg;

  localparam int PAGE_BITS = 13;
  localparam int PAGE_BYTES = 8192;
  localparam int ADDR_W = 14;

  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_FETCH = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_CTRL  = 3'd3,
    ACT_LOAD  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_HOST,
    MEM_IROM,
    MEM_RAM
  } mem_t;

  typedef enum logic [1:0] {
    SRC_HOST,
    SRC_IROM,
    SRC_RAM3
  } src_t;

  localparam logic [1:0] LOW_PAGE = 2'd3;
  localparam logic [5:0] HIT_TAG = 6'h3D;
  localparam logic [10:0] UNMAP_TAG = 11'h3FF;

  localparam logic [ADDR_W-1:0] TRAP_RESET = 14'h0000;
  localparam logic [ADDR_W-1:0] TRAP_RST8 = 14'h0008;
  localparam logic [ADDR_W-1:0] TRAP_INT = 14'h0038;
  localparam logic [ADDR_W-1:0] TRAP_NMI = 14'h0066;
  localparam logic [ADDR_W-1:0] TRAP_SAVE = 14'h04C6;
  localparam logic [ADDR_W-1:0] TRAP_LOAD = 14'h0562;

  localparam int CTRL_MAPRAM = 6;
  localparam int CTRL_CONMEM = 7;

  typedef struct packed {
    mem_t              mem;
    logic              wr;
    logic [1:0]        page;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              mapped;
  } rtap_op_t;

endpackage

/* sv/rom_trap_automap_paging.sv */
// top level of the rom trap automap pager
// depends on rtap_pkg, rtap_front, rtap_queue, rtap_back
`timescale 1ns / 1ps
//
// usage
// - input channel: in_valid/in_stall carry one bus access per beat (action,
//   address, data, load_target); a beat is taken when in_valid is high and
//   in_stall is low
// - output channel: out_valid/out_stall carry one result beat per access,
//   read_data (zero for anything but reads and fetches) and mapped
// - config: cfg_write_enable/cfg_write_data set rom_write_enable, used from
//   the next control port write on; write it only while the block is idle
// - result path: a taken access goes into the queue and, once popped, into
//   the memory read registers and out_valid, which offer its result beat
// - throughput: one access per cycle unless out_stall holds results; set by
//   the single port of each memory: one operation per cycle in the back end
// - in_stall rises when the two-entry queue fills, which happens only while
//   result beats are held by out_stall
// - reset (rst, synchronous) unmaps the interface memory, clears page,
//   conmem and mapram, and empties queue and output stage; memory contents
//   are left as they are and must be loaded or written before being read
//
module rom_trap_automap_paging
  import rtap_pkg::*;
#(
  parameter int RAM_PAGES = 4
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [13:0] address,
  input  logic [7:0]  data,
  input  logic        load_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        mapped,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data
);

  logic     accept;
  logic     full;
  logic     pop;
  logic     head_valid;
  rtap_op_t front_op;
  rtap_op_t head_op;

  assign in_stall = full;
  assign accept = in_valid && !full;

  rtap_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .action           (action),
    .address          (address),
    .data             (data),
    .load_target      (load_target),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .op               (front_op)
  );

  rtap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_op    (front_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  rtap_back #(
    .RAM_PAGES (RAM_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .mapped     (mapped)
  );

endmodule

/* sv/rtap_front.sv */
// front end: paging state, classifies each beat into one memory operation
// depends on rtap_pkg
`timescale 1ns / 1ps

module rtap_front
  import rtap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        action,
  input  logic [ADDR_W-1:0] address,
  input  logic [7:0]        data,
  input  logic              load_target,
  input  logic              cfg_write_enable,
  input  logic              cfg_write_data,
  output rtap_op_t          op
);

  logic       is_mapped, is_mapped_next;
  logic [1:0] page_select, page_select_next;
  logic       conmem, conmem_next;
  logic       mapram, mapram_next;
  src_t       low_source, low_source_next;
  logic       high_source, high_source_next;
  logic       low_bank_choice, low_bank_choice_next;
  logic       low_writable, low_writable_next;
  logic       high_writable, high_writable_next;
  logic       rom_write_enable;
  logic       lo;
  logic       hit;
  logic       trap;

  function automatic mem_t route(logic low, src_t ls, logic hs);
    mem_t m;
    if (low) begin
      unique case (ls)
        SRC_IROM: m = MEM_IROM;
        SRC_RAM3: m = MEM_RAM;
        default:  m = MEM_HOST;
      endcase
    end else begin
      m = hs ? MEM_RAM : MEM_HOST;
    end
    return m;
  endfunction

  assign lo = ~address[ADDR_W-1];
  assign hit = address[ADDR_W-1:8] == HIT_TAG;
  assign trap = (address == TRAP_RESET) || (address == TRAP_RST8) ||
                (address == TRAP_INT) || (address == TRAP_NMI) ||
                (address == TRAP_SAVE) || (address == TRAP_LOAD);

  always_comb begin
    is_mapped_next = is_mapped;
    page_select_next = page_select;
    conmem_next = conmem;
    mapram_next = mapram;
    low_source_next = low_source;
    high_source_next = high_source;
    low_bank_choice_next = low_bank_choice;
    low_writable_next = low_writable;
    high_writable_next = high_writable;
    op.mem = MEM_NONE;
    op.wr = 1'b0;
    op.page = lo ? LOW_PAGE : page_select;
    op.addr = address;
    op.data = data;
    unique case (action_t'(action))
      ACT_READ: begin
        op.mem = route(lo, low_source, high_source);
      end
      ACT_FETCH: begin
        if (!lo) begin
          op.mem = route(1'b0, low_source, high_source | hit);
          if (hit) begin
            high_source_next = 1'b1;
            low_source_next = low_bank_choice ? SRC_RAM3 : SRC_IROM;
            is_mapped_next = 1'b1;
          end
        end else begin
          op.mem = route(1'b1, low_source, high_source);
          if (address[ADDR_W-1:3] == UNMAP_TAG) begin
            if (!conmem) begin
              low_source_next = SRC_HOST;
              high_source_next = 1'b0;
              is_mapped_next = 1'b0;
            end
          end else if (trap) begin
            high_source_next = 1'b1;
            low_source_next = low_bank_choice ? SRC_RAM3 : SRC_IROM;
            is_mapped_next = 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        op.wr = 1'b1;
        if (is_mapped) begin
          if (lo) begin
            if (low_writable && low_source == SRC_IROM) begin
              op.mem = MEM_IROM;
            end else if (low_writable && low_source == SRC_RAM3) begin
              op.mem = MEM_RAM;
            end
          end else if (high_writable && high_source) begin
            op.mem = MEM_RAM;
          end
        end
      end
      ACT_CTRL: begin
        page_select_next = data[1:0];
        conmem_next = data[CTRL_CONMEM];
        if (!data[CTRL_CONMEM] && (mapram || data[CTRL_MAPRAM])) begin
          mapram_next = 1'b1;
          low_bank_choice_next = 1'b1;
          low_writable_next = 1'b0;
          high_writable_next = data[1:0] != LOW_PAGE;
        end else begin
          low_bank_choice_next = 1'b0;
          low_writable_next = rom_write_enable;
          high_writable_next = 1'b1;
        end
        if (is_mapped || data[CTRL_CONMEM]) begin
          high_source_next = 1'b1;
          low_source_next = low_bank_choice_next ? SRC_RAM3 : SRC_IROM;
          is_mapped_next = 1'b1;
        end else begin
          low_source_next = SRC_HOST;
          high_source_next = 1'b0;
          is_mapped_next = 1'b0;
        end
      end
      ACT_LOAD: begin
        op.wr = 1'b1;
        if (!load_target) begin
          op.mem = MEM_HOST;
        end else if (lo) begin
          op.mem = MEM_IROM;
        end
      end
      default: begin
        op.mem = MEM_NONE;
      end
    endcase
    op.mapped = is_mapped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_mapped <= 1'b0;
      page_select <= 2'd0;
      conmem <= 1'b0;
      mapram <= 1'b0;
      low_source <= SRC_HOST;
      high_source <= 1'b0;
      low_bank_choice <= 1'b0;
      low_writable <= 1'b1;
      high_writable <= 1'b1;
      rom_write_enable <= 1'b1;
    end else begin
      if (cfg_write_enable) begin
        rom_write_enable <= cfg_write_data;
      end
      if (accept) begin
        is_mapped <= is_mapped_next;
        page_select <= page_select_next;
        conmem <= conmem_next;
        mapram <= mapram_next;
        low_source <= low_source_next;
        high_source <= high_source_next;
        low_bank_choice <= low_bank_choice_next;
        low_writable <= low_writable_next;
        high_writable <= high_writable_next;
      end
    end
  end

endmodule

/* sv/rtap_queue.sv */
// two-entry operation queue between front and back end
// depends on rtap_pkg
`timescale 1ns / 1ps

module rtap_queue
  import rtap_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rtap_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output rtap_op_t head_op
);

  rtap_op_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/rtap_back.sv */
// back end: host rom copy, interface rom and paged ram, output register
// depends on rtap_pkg
`timescale 1ns / 1ps

module rtap_back
  import rtap_pkg::*;
#(
  parameter int RAM_PAGES = 4
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  rtap_op_t head_op,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [7:0] read_data,
  output logic     mapped
);

  localparam int PW = $clog2(RAM_PAGES);
  localparam int RAM_AW = PW + PAGE_BITS;

  logic [7:0]        host_mem [2 * PAGE_BYTES];
  logic [7:0]        irom_mem [PAGE_BYTES];
  logic [7:0]        ram_mem [RAM_PAGES * PAGE_BYTES];
  logic [7:0]        host_q;
  logic [7:0]        irom_q;
  logic [7:0]        ram_q;
  mem_t              sel;
  logic [PW-1:0]     page_wrapped;
  logic [RAM_AW-1:0] ram_addr;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    if (int'(head_op.page) >= RAM_PAGES) begin
      page_wrapped = PW'(int'(head_op.page) - RAM_PAGES);
    end else begin
      page_wrapped = PW'(head_op.page);
    end
  end

  assign ram_addr = {page_wrapped, head_op.addr[PAGE_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (pop && head_op.mem == MEM_HOST) begin
      if (head_op.wr) begin
        host_mem[head_op.addr] <= head_op.data;
      end else begin
        host_q <= host_mem[head_op.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.mem == MEM_IROM) begin
      if (head_op.wr) begin
        irom_mem[head_op.addr[PAGE_BITS-1:0]] <= head_op.data;
      end else begin
        irom_q <= irom_mem[head_op.addr[PAGE_BITS-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.mem == MEM_RAM) begin
      if (head_op.wr) begin
        ram_mem[ram_addr] <= head_op.data;
      end else begin
        ram_q <= ram_mem[ram_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sel <= head_op.wr ? MEM_NONE : head_op.mem;
      mapped <= head_op.mapped;
    end
  end

  always_comb begin
    unique case (sel)
      MEM_HOST: read_data = host_q;
      MEM_IROM: read_data = irom_q;
      MEM_RAM:  read_data = ram_q;
      default:  read_data = 8'd0;
    endcase
  end

endmodule

/* sv/rtap_checker.sv */
// port-level checks for the rom trap automap pager, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtap_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       mapped
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(read_data) && $stable(mapped), "stalled result changed")
  `ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "result offered straight after reset")
  `ASSERT_NOW(a_rise_cause, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an access two cycles earlier")

endmodule

bind rom_trap_automap_paging rtap_checker u_rtap_checker (.*);
